// ----- rtl/stylus_tilt_report_builder_macros.svh -----
// Assertion macros shared by the stylus tilt report builder RTL.
// Depends on nothing; the including module supplies aclk and aresetn.
`ifndef STYLUS_TILT_REPORT_BUILDER_MACROS_SVH
`define STYLUS_TILT_REPORT_BUILDER_MACROS_SVH

// Implication within the same cycle, quiet during reset.
`define STRB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the following cycle, quiet during reset.
`define STRB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/strb_pkg.sv -----
// Package for the stylus tilt report builder: widths, stage payload types,
// the arctangent table and the CORDIC step functions. Depends on nothing.
package strb_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int RW               = 20;  // rotation x/y, Q16 with gain
    localparam int ZW               = 36;  // angles, 0.01 degree with 16 fraction bits
    localparam int PW               = 40;  // products and vectoring x/y

    localparam longint ATAN_TAB [TABLE_LEN] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466765, 733385, 366693, 183346,
        91673, 45837, 22918, 11459, 5730, 2865,
        1432, 716, 358, 179, 90, 45
    };

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(longint'(18000) * 65536);

    typedef struct packed {
        logic        hover;
        logic        touch;
        logic        barrel;
        logic        eraser;
        logic [15:0] out_x;
        logic [15:0] out_y;
        logic [15:0] tip_force;
        logic [15:0] report_stamp;
        logic        alt_zero;
    } side_t;

    typedef struct packed {
        logic signed [RW-1:0] ax;
        logic signed [RW-1:0] ay;
        logic signed [ZW-1:0] az;
        logic                 aflip;
        logic signed [RW-1:0] bx;
        logic signed [RW-1:0] by;
        logic signed [ZW-1:0] bz;
        logic                 bflip;
    } rot_t;

    typedef struct packed {
        logic signed [PW-1:0] yv;
        logic signed [PW-1:0] xc;
        logic signed [PW-1:0] xs;
    } prod_t;

    typedef struct packed {
        logic signed [PW-1:0] ux;
        logic signed [PW-1:0] uy;
        logic signed [ZW-1:0] uz;
        logic                 uzero;
        logic signed [PW-1:0] vx;
        logic signed [PW-1:0] vy;
        logic signed [ZW-1:0] vz;
        logic                 vzero;
    } vec_t;

    typedef struct packed {
        logic signed [ZW-1:0] z;
        logic                 flip;
    } red_t;

    // Angle modulo a full turn, folded into -9000..9000 with a cosine flip.
    function automatic red_t strb_reduce(input logic [15:0] a);
        logic [15:0]        m;
        logic signed [17:0] s;
        red_t               r;
        m = (a >= 16'd36000) ? 16'(a - 16'd36000) : a;
        s = signed'({2'b00, m});
        r.flip = 1'b0;
        if (s >= 18'sd18000) begin
            s = s - 18'sd36000;
        end
        if (s > 18'sd9000) begin
            s = 18'sd18000 - s;
            r.flip = 1'b1;
        end else if (s < -18'sd9000) begin
            s = -18'sd18000 - s;
            r.flip = 1'b1;
        end
        r.z = {{(ZW-34){s[17]}}, s, 16'b0};
        return r;
    endfunction

    // Gain reference: x after rotating (1.0, 0) by angle zero.
    function automatic longint strb_gain(input int steps);
        longint x, y, z, dx, dy;
        x = 65536;
        y = 0;
        z = 0;
        for (int i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TAB[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TAB[i];
            end
        end
        return x;
    endfunction

    function automatic rot_t strb_rot_step(input rot_t r, input int i);
        rot_t                 n;
        logic signed [ZW-1:0] t;
        t = ZW'(ATAN_TAB[i]);
        n = r;
        if (r.az >= 0) begin
            n.ax = r.ax - (r.ay >>> i);
            n.ay = r.ay + (r.ax >>> i);
            n.az = r.az - t;
        end else begin
            n.ax = r.ax + (r.ay >>> i);
            n.ay = r.ay - (r.ax >>> i);
            n.az = r.az + t;
        end
        if (r.bz >= 0) begin
            n.bx = r.bx - (r.by >>> i);
            n.by = r.by + (r.bx >>> i);
            n.bz = r.bz - t;
        end else begin
            n.bx = r.bx + (r.by >>> i);
            n.by = r.by - (r.bx >>> i);
            n.bz = r.bz + t;
        end
        return n;
    endfunction

    function automatic vec_t strb_vec_step(input vec_t v, input int i);
        vec_t                 n;
        logic signed [ZW-1:0] t;
        t = ZW'(ATAN_TAB[i]);
        n = v;
        if (v.uy >= 0) begin
            n.ux = v.ux + (v.uy >>> i);
            n.uy = v.uy - (v.ux >>> i);
            n.uz = v.uz + t;
        end else begin
            n.ux = v.ux - (v.uy >>> i);
            n.uy = v.uy + (v.ux >>> i);
            n.uz = v.uz - t;
        end
        if (v.vy >= 0) begin
            n.vx = v.vx + (v.vy >>> i);
            n.vy = v.vy - (v.vx >>> i);
            n.vz = v.vz + t;
        end else begin
            n.vx = v.vx - (v.vy >>> i);
            n.vy = v.vy + (v.vx >>> i);
            n.vz = v.vz - t;
        end
        return n;
    endfunction

    // Angle to whole hundredths, halves away from zero.
    function automatic logic signed [15:0] strb_round(input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] mag;
        logic signed [ZW-1:0] r;
        mag = (z < 0) ? -z : z;
        r = (mag + ZW'(32768)) >>> 16;
        return (z < 0) ? -r[15:0] : r[15:0];
    endfunction

endpackage

// ----- rtl/stylus_tilt_report_builder.sv -----
// Top level of the stylus tilt report builder: a fully pipelined pair of
// CORDIC units turning pen altitude and azimuth into x/y tilt. Uses strb_pkg.
//
//   channel | direction | handshake          | contents
//   s_*     | in        | s_valid / s_ready  | one pen sample per request
//   m_*     | out       | m_valid / m_ready  | one stylus report per request
//
// Each request passes through 2*CORDIC_STEPS+4 register stages (36 at the
// default), one stage per CORDIC iteration, and its report is offered from
// the output stage; a new request can enter on every cycle unless every
// stage is full and m_ready is low. Reset (aresetn low at a clock edge)
// clears only the stage valid bits. Every stage holds its request while
// the stage after it is full and stalled, so an empty stage anywhere lets
// input be taken even while a finished report waits on m_ready.
module stylus_tilt_report_builder
    import strb_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_proximity,
    input  logic               s_contact,
    input  logic               s_button,
    input  logic               s_rubber,
    input  logic [15:0]        s_pos_x,
    input  logic [15:0]        s_pos_y,
    input  logic [15:0]        s_pressure,
    input  logic [14:0]        s_altitude,
    input  logic [15:0]        s_azimuth,
    input  logic [15:0]        s_stamp,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hover,
    output logic               m_touch,
    output logic               m_barrel,
    output logic               m_inverted,
    output logic               m_eraser,
    output logic [15:0]        m_out_x,
    output logic [15:0]        m_out_y,
    output logic [15:0]        m_tip_force,
    output logic signed [15:0] m_tilt_x,
    output logic signed [15:0] m_tilt_y,
    output logic [15:0]        m_report_stamp
);

`include "stylus_tilt_report_builder_macros.svh"

    // Stage map: 0 angle reduction, 1..N rotation steps, N+1 products,
    // N+2 vectoring set-up, N+3..2N+2 vectoring steps, 2N+3 output.
    localparam int N       = CORDIC_STEPS;
    localparam int L       = 2 * N + 4;
    localparam int S_MUL   = N + 1;
    localparam int S_VPRE  = N + 2;
    localparam int S_OUT   = L - 1;
    localparam logic signed [RW-1:0] Gain = RW'(strb_gain(CORDIC_STEPS));

    logic  valid_reg [L];
    logic  en        [L];
    side_t side_reg  [L];
    rot_t  rot_reg   [N+1];
    prod_t prod_reg;
    vec_t  vec_reg   [N+1];
    logic signed [15:0] tilt_x_reg;
    logic signed [15:0] tilt_y_reg;

    // Ready ripples back from the output: a stage may load when it is
    // empty or when its own request moves on in the same cycle.
    always_comb begin
        en[L-1] = !valid_reg[L-1] || m_ready;
        for (int i = L - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[0];

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < L; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < L; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // Pass-through fields ride alongside the arithmetic.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_reg[0].hover        <= s_proximity;
            side_reg[0].touch        <= s_contact;
            side_reg[0].barrel       <= s_button & s_contact;
            side_reg[0].eraser       <= s_rubber;
            side_reg[0].out_x        <= s_pos_x;
            side_reg[0].out_y        <= s_pos_y;
            side_reg[0].tip_force    <= s_pressure;
            side_reg[0].report_stamp <= s_stamp;
            side_reg[0].alt_zero     <= (s_altitude == '0);
        end
        for (int i = 1; i < L; i++) begin
            if (en[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Stage 0: fold both angles into the CORDIC convergence range.
    red_t red_alt;
    red_t red_azm;
    rot_t rot_next;

    always_comb begin
        red_alt        = strb_reduce({1'b0, s_altitude});
        red_azm        = strb_reduce(s_azimuth);
        rot_next.ax    = RW'(65536);
        rot_next.ay    = '0;
        rot_next.az    = red_alt.z;
        rot_next.aflip = red_alt.flip;
        rot_next.bx    = RW'(65536);
        rot_next.by    = '0;
        rot_next.bz    = red_azm.z;
        rot_next.bflip = red_azm.flip;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            rot_reg[0] <= rot_next;
        end
    end

    // Rotation mode: one iteration per stage, both angles side by side.
    for (genvar k = 0; k < N; k++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (en[k+1]) begin
                rot_reg[k+1] <= strb_rot_step(rot_reg[k], k);
            end
        end
    end

    // Products: the cosine of altitude is scaled by the gain reference so
    // that both parts of the vector carry the squared gain.
    logic signed [RW-1:0] cos_alt;
    logic signed [RW-1:0] cos_azm;
    prod_t                prod_next;

    always_comb begin
        cos_alt = rot_reg[N].aflip ? -rot_reg[N].ax : rot_reg[N].ax;
        cos_azm = rot_reg[N].bflip ? -rot_reg[N].bx : rot_reg[N].bx;
        prod_next.yv = PW'(cos_alt) * PW'(Gain);
        prod_next.xc = PW'(rot_reg[N].ay) * PW'(cos_azm);
        prod_next.xs = PW'(rot_reg[N].ay) * PW'(rot_reg[N].by);
    end

    always_ff @(posedge aclk) begin
        if (en[S_MUL]) begin
            prod_reg <= prod_next;
        end
    end

    // Vectoring set-up: a vector in the left half-plane is turned by half
    // a turn first, and a zero vector is flagged to give angle zero.
    vec_t vec_next;

    always_comb begin
        vec_next.uzero = (prod_reg.xc == '0) && (prod_reg.yv == '0);
        vec_next.vzero = (prod_reg.xs == '0) && (prod_reg.yv == '0);
        if (prod_reg.xc < 0) begin
            vec_next.uz = (prod_reg.yv >= 0) ? HALF_TURN : -HALF_TURN;
            vec_next.ux = -prod_reg.xc;
            vec_next.uy = -prod_reg.yv;
        end else begin
            vec_next.uz = '0;
            vec_next.ux = prod_reg.xc;
            vec_next.uy = prod_reg.yv;
        end
        if (prod_reg.xs < 0) begin
            vec_next.vz = (prod_reg.yv >= 0) ? HALF_TURN : -HALF_TURN;
            vec_next.vx = -prod_reg.xs;
            vec_next.vy = -prod_reg.yv;
        end else begin
            vec_next.vz = '0;
            vec_next.vx = prod_reg.xs;
            vec_next.vy = prod_reg.yv;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[S_VPRE]) begin
            vec_reg[0] <= vec_next;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_vec
        always_ff @(posedge aclk) begin
            if (en[S_VPRE+k+1]) begin
                vec_reg[k+1] <= strb_vec_step(vec_reg[k], k);
            end
        end
    end

    // Output stage: round the angles, offset by a quarter turn, zero if level.
    logic signed [15:0] ang_x;
    logic signed [15:0] ang_y;
    logic signed [15:0] tilt_x_next;
    logic signed [15:0] tilt_y_next;

    always_comb begin
        ang_x = vec_reg[N].uzero ? 16'sd0 : strb_round(vec_reg[N].uz);
        ang_y = vec_reg[N].vzero ? 16'sd0 : strb_round(vec_reg[N].vz);
        if (side_reg[S_OUT-1].alt_zero) begin
            tilt_x_next = 16'sd0;
            tilt_y_next = 16'sd0;
        end else begin
            tilt_x_next = 16'sd9000 - ang_x;
            tilt_y_next = ang_y - 16'sd9000;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[S_OUT]) begin
            tilt_x_reg <= tilt_x_next;
            tilt_y_reg <= tilt_y_next;
        end
    end

    assign m_valid        = valid_reg[S_OUT];
    assign m_hover        = side_reg[S_OUT].hover;
    assign m_touch        = side_reg[S_OUT].touch;
    assign m_barrel       = side_reg[S_OUT].barrel;
    assign m_inverted     = side_reg[S_OUT].eraser;
    assign m_eraser       = side_reg[S_OUT].eraser;
    assign m_out_x        = side_reg[S_OUT].out_x;
    assign m_out_y        = side_reg[S_OUT].out_y;
    assign m_tip_force    = side_reg[S_OUT].tip_force;
    assign m_tilt_x       = tilt_x_reg;
    assign m_tilt_y       = tilt_y_reg;
    assign m_report_stamp = side_reg[S_OUT].report_stamp;

    // A level pen must always report zero tilt.
    `STRB_ASSERT_NOW(a_alt_zero_tilt, m_valid && side_reg[S_OUT].alt_zero,
        (m_tilt_x == 16'sd0) && (m_tilt_y == 16'sd0), "zero altitude gave nonzero tilt")
    // Input is refused only when the first stage is full and blocked.
    `STRB_ASSERT_NOW(a_ready_blocked, !s_ready, valid_reg[0] && !en[1],
        "input refused with room in the first stage")
    // The side button never shows without tip contact.
    `STRB_ASSERT_NOW(a_side_gated, m_valid && m_barrel, m_touch,
        "side button reported without contact")
    // A stalled report is held, not replaced.
    `STRB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(tilt_x_reg) && $stable(tilt_y_reg), "stalled report changed")

endmodule
